>>> hdl/sfwd_pkg.sv
// Shared constants and types of the serial frame window deframer.
package sfwd_pkg;

   localparam int FRAME_BYTES_DEF = 19;

   localparam logic [7:0] START_MARKER_RST = 8'h40;
   localparam logic [7:0] END_MARKER_RST   = 8'h2B;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_START_MARKER = 1'b0;
   localparam logic REG_END_MARKER   = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // Frame check request that travels from the window to the result stage.
   typedef struct packed {
      logic pend;
      logic hit;
      logic sum_ok;
   } chk_type;

endpackage

>>> hdl/serial_frame_window_deframer.sv
// Top level of the serial frame window deframer.
//
// Usage: every item on the req_ channel carries one byte received from a
// serial link. The bytes enter a row of FRAME_BYTES byte cells. Until the
// row is full each byte lands in the next free cell; after that every new
// byte enters the last cell and all others move one cell toward the front.
// After each byte the window is checked: when its first byte equals the
// start marker and its last byte equals the end marker, one item leaves on
// the rsp_ channel with status zero and four little-endian words from bytes
// 2 to 17, or with status one and zero words when the XOR of bytes 2 to
// FRAME_BYTES-2 differs from byte 1. Other bytes give no item.
// The XOR is kept as a running value updated with every byte. One byte is
// taken every cycle while req_stall is low. An output register and a
// one-deep check stage part the channels; req_stall rises only when a check
// waits behind a stalled result item. Reset empties the window, clears all
// bytes to zero and restores the markers to '@' and '+'. The markers are
// written over the APB-style port at byte addresses 0 and 4; the user must
// write them only while the block is idle; the block does not enforce it.
module serial_frame_window_deframer #(
   parameter int FRAME_BYTES = sfwd_pkg::FRAME_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_status,
   output logic [31:0]                     rsp_thrust_bits,
   output logic [31:0]                     rsp_rate_x_bits,
   output logic [31:0]                     rsp_rate_y_bits,
   output logic [31:0]                     rsp_rate_z_bits,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sfwd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sfwd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sfwd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import sfwd_pkg::*;

   localparam int FILL_W = $clog2(FRAME_BYTES + 1);

   // Configuration registers.
   logic [7:0] start_ff;
   logic [7:0] start_in;
   logic [7:0] end_ff;
   logic [7:0] end_in;
   logic       csr_wr;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_wr) begin
         case (reg_sel)
            REG_START_MARKER: begin
               start_in = pwdata[7:0];
            end
            REG_END_MARKER: begin
               end_in = pwdata[7:0];
            end
            default: begin
               start_in = start_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_START_MARKER: prdata = {{(CSR_DATA_W-8){1'b0}}, start_ff};
         REG_END_MARKER:   prdata = {{(CSR_DATA_W-8){1'b0}}, end_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_MARKER_RST;
         end_ff   <= END_MARKER_RST;
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   // Byte window: a chain of cells, the last one fed by the incoming byte.
   logic              accept;
   logic              hold;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              full;
   logic [7:0]        win [FRAME_BYTES];

   assign req_stall = hold;
   assign accept    = req_valid && !hold;
   assign full      = (fill_ff == FILL_W'(FRAME_BYTES));

   genvar gi;
   generate
      for (gi = 0; gi < FRAME_BYTES; gi++) begin : g_cell
         logic [7:0] next_byte;
         if (gi == FRAME_BYTES - 1) begin : g_last
            assign next_byte = req_rx_byte;
         end else begin : g_mid
            assign next_byte = win[gi+1];
         end
         sfwd_cell #(
            .INDEX  (gi),
            .FILL_W (FILL_W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .accept    (accept),
            .full      (full),
            .fill      (fill_ff),
            .next_byte (next_byte),
            .rx_byte   (req_rx_byte),
            .data      (win[gi])
         );
      end
   endgenerate

   always_comb begin
      fill_in = fill_ff;
      if (accept && !full) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   // Running XOR of bytes 2 to FRAME_BYTES-2. While filling, a new byte in
   // that span is folded in; once full, byte 2 leaves the span and the last
   // byte enters it.
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic       fill_in_span;

   assign fill_in_span = (fill_ff >= FILL_W'(2)) && (fill_ff <= FILL_W'(FRAME_BYTES - 2));

   always_comb begin
      sum_in = sum_ff;
      if (accept) begin
         if (full) begin
            sum_in = sum_ff ^ win[2] ^ win[FRAME_BYTES-1];
         end else if (fill_in_span) begin
            sum_in = sum_ff ^ req_rx_byte;
         end
      end
   end

   // A check is pending after every byte and stays pending while the
   // result register is blocked.
   logic pend_ff;
   logic pend_in;

   assign pend_in = accept || hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         sum_ff  <= 8'h00;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         pend_ff <= pend_in;
      end
   end

   chk_type chk;

   assign chk.pend   = pend_ff;
   assign chk.hit    = (win[0] == start_ff) && (win[FRAME_BYTES-1] == end_ff);
   assign chk.sum_ok = (sum_ff == win[1]);

   sfwd_out u_out (
      .clock           (clock),
      .reset           (reset),
      .chk             (chk),
      .thrust_word     ({win[5],  win[4],  win[3],  win[2]}),
      .rate_x_word     ({win[9],  win[8],  win[7],  win[6]}),
      .rate_y_word     ({win[13], win[12], win[11], win[10]}),
      .rate_z_word     ({win[17], win[16], win[15], win[14]}),
      .hold            (hold),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_thrust_bits (rsp_thrust_bits),
      .rsp_rate_x_bits (rsp_rate_x_bits),
      .rsp_rate_y_bits (rsp_rate_y_bits),
      .rsp_rate_z_bits (rsp_rate_z_bits)
   );
endmodule

>>> hdl/sfwd_cell.sv
// One byte cell of the receive window shift chain.
module sfwd_cell #(
   parameter int INDEX  = 0,
   parameter int FILL_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              full,
   input  logic [FILL_W-1:0] fill,
   input  logic [7:0]        next_byte,
   input  logic [7:0]        rx_byte,
   output logic [7:0]        data
);
   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (accept) begin
         if (full) begin
            data_in = next_byte;
         end else if (fill == FILL_W'(INDEX)) begin
            data_in = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= 8'h00;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;
endmodule

>>> hdl/sfwd_out.sv
// Result stage: holds one finished frame item until the receiver takes it.
module sfwd_out (
   input  logic                 clock,
   input  logic                 reset,
   input  sfwd_pkg::chk_type    chk,
   input  logic [31:0]          thrust_word,
   input  logic [31:0]          rate_x_word,
   input  logic [31:0]          rate_y_word,
   input  logic [31:0]          rate_z_word,
   output logic                 hold,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_status,
   output logic [31:0]          rsp_thrust_bits,
   output logic [31:0]          rsp_rate_x_bits,
   output logic [31:0]          rsp_rate_y_bits,
   output logic [31:0]          rsp_rate_z_bits
);
   import sfwd_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic        status_ff;
   logic [31:0] thrust_ff;
   logic [31:0] rate_x_ff;
   logic [31:0] rate_y_ff;
   logic [31:0] rate_z_ff;
   logic        slot_free;
   logic        load;

   assign slot_free = !valid_ff || !rsp_stall;
   assign load      = chk.pend && chk.hit && slot_free;
   assign hold      = chk.pend && !slot_free;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // A checksum mismatch reports zero words.
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= chk.sum_ok ? STATUS_OK : STATUS_BAD;
         thrust_ff <= chk.sum_ok ? thrust_word : 32'h0;
         rate_x_ff <= chk.sum_ok ? rate_x_word : 32'h0;
         rate_y_ff <= chk.sum_ok ? rate_y_word : 32'h0;
         rate_z_ff <= chk.sum_ok ? rate_z_word : 32'h0;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_thrust_bits = thrust_ff;
   assign rsp_rate_x_bits = rate_x_ff;
   assign rsp_rate_y_bits = rate_y_ff;
   assign rsp_rate_z_bits = rate_z_ff;
endmodule

>>> hdl/sfwd_checker.sv
// Port checker for the serial frame window deframer, with its bind.
module sfwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic [31:0] rsp_thrust_bits,
   input logic [31:0] rsp_rate_x_bits,
   input logic [31:0] rsp_rate_y_bits,
   input logic [31:0] rsp_rate_z_bits
);
   // A stalled result item stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // A checksum error carries zero words.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         rsp_thrust_bits == 32'h0 && rsp_rate_x_bits == 32'h0 &&
         rsp_rate_y_bits == 32'h0 && rsp_rate_z_bits == 32'h0)
      else $error("checksum error item with nonzero words");

   // Input backpressure only comes from a stalled result.
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // No result item right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item offered after reset");
endmodule

bind serial_frame_window_deframer sfwd_checker u_sfwd_checker (.*);

>>> tb/frame_checker.sv
// Checker that predicts deframer result items from accepted bytes and compares them.
`timescale 1ns / 1ps

module frame_checker #(
   parameter int FRAME_BYTES = sfwd_pkg::FRAME_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_status,
   input  logic [31:0]                     rsp_thrust_bits,
   input  logic [31:0]                     rsp_rate_x_bits,
   input  logic [31:0]                     rsp_rate_y_bits,
   input  logic [31:0]                     rsp_rate_z_bits,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sfwd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sfwd_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [sfwd_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                            pready,
   output int                              mismatches,
   output int                              frames_awaited
);
   import sfwd_pkg::*;

   typedef struct packed {
      logic        status;
      logic [31:0] thrust;
      logic [31:0] rate_x;
      logic [31:0] rate_y;
      logic [31:0] rate_z;
   } frame_fields_t;

   logic [7:0]    window_q [FRAME_BYTES];
   int            bytes_held;
   logic [7:0]    start_mark;
   logic [7:0]    end_mark;
   frame_fields_t frames_due [$];
   int            fails = 0;

   assign mismatches = fails;

   initial frames_awaited = 0;

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(input logic idx);
      logic [CSR_ADDR_W-1:0] a;
      a    = '0;
      a[2] = idx;
      return a;
   endfunction

   function automatic logic [31:0] le_word(input int pos);
      return {window_q[pos+3], window_q[pos+2], window_q[pos+1], window_q[pos]};
   endfunction

   // Shifts one byte into the window and tells whether the new window
   // forms a frame; the frame's fields come back in f.
   function automatic bit deframe(input logic [7:0] b, output frame_fields_t f);
      logic [7:0] sum;
      f = '0;
      if (bytes_held >= FRAME_BYTES) begin
         for (int i = 0; i < FRAME_BYTES - 1; i++) window_q[i] = window_q[i+1];
         window_q[FRAME_BYTES-1] = b;
      end else begin
         window_q[bytes_held] = b;
         bytes_held++;
      end
      if (window_q[0] != start_mark || window_q[FRAME_BYTES-1] != end_mark) return 1'b0;
      sum = '0;
      for (int i = 2; i <= FRAME_BYTES - 2; i++) sum ^= window_q[i];
      if (sum != window_q[1]) begin
         f.status = STATUS_BAD;
         return 1'b1;
      end
      f.status = STATUS_OK;
      f.thrust = le_word(2);
      f.rate_x = le_word(6);
      f.rate_y = le_word(10);
      f.rate_z = le_word(14);
      return 1'b1;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %h, actual %h", name, want_v, got_v);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      frame_fields_t want;
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) window_q[i] = '0;
         bytes_held = 0;
         start_mark = START_MARKER_RST;
         end_mark   = END_MARKER_RST;
         frames_due.delete();
      end else begin
         if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
            if (pwrite === 1'b1) begin
               if (paddr == reg_addr(REG_START_MARKER)) start_mark = pwdata[7:0];
               else if (paddr == reg_addr(REG_END_MARKER)) end_mark = pwdata[7:0];
            end else if (paddr == reg_addr(REG_START_MARKER)) begin
               compare_field("prdata start_marker", {24'b0, start_mark}, prdata);
            end else if (paddr == reg_addr(REG_END_MARKER)) begin
               compare_field("prdata end_marker", {24'b0, end_mark}, prdata);
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            if (deframe(req_rx_byte, want)) frames_due.push_back(want);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (frames_due.size() == 0) begin
               $error("result item with no frame pending: status %b thrust %h",
                      rsp_status, rsp_thrust_bits);
               fails++;
            end else begin
               want = frames_due.pop_front();
               compare_field("status", {31'b0, want.status}, {31'b0, rsp_status});
               compare_field("thrust_bits", want.thrust, rsp_thrust_bits);
               compare_field("rate_x_bits", want.rate_x, rsp_rate_x_bits);
               compare_field("rate_y_bits", want.rate_y, rsp_rate_y_bits);
               compare_field("rate_z_bits", want.rate_z, rsp_rate_z_bits);
            end
         end
      end
      frames_awaited <= frames_due.size();
   end

endmodule

>>> tb/testbench.sv
// Top of the deframer testbench: clock, reset, byte stimulus, marker setup and verdict.
`timescale 1ns / 1ps

module testbench;
   import sfwd_pkg::*;

   localparam int FRAME_BYTES     = FRAME_BYTES_DEF;
   localparam int LIMIT_CYCLES    = 300000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int NUM_PHASES      = 6;
   localparam int PHASE_BYTES     = 320;

   // What the sender puts on the link next.
   typedef enum {FR_GOOD, FR_BAD_SUM, FR_OVERLAP, FR_NOISE} frame_kind_t;

   // How hard the result side pushes back during one run of cycles.
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic [7:0]            req_rx_byte = '0;
   logic                  rsp_stall   = 1'b0;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;

   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_status;
   logic [31:0]           rsp_thrust_bits;
   logic [31:0]           rsp_rate_x_bits;
   logic [31:0]           rsp_rate_y_bits;
   logic [31:0]           rsp_rate_z_bits;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    mismatches;
   int                    frames_awaited;

   // Marker values currently programmed; the frame builder uses them so
   // that most of the random traffic really forms frames.
   logic [7:0]            cur_start = START_MARKER_RST;
   logic [7:0]            cur_end   = END_MARKER_RST;

   // Sender burst bookkeeping and the request for one long result hold-off.
   int                    burst_left   = 0;
   int                    bytes_sent   = 0;
   bit                    hold_off_req = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   serial_frame_window_deframer #(
      .FRAME_BYTES (FRAME_BYTES)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_thrust_bits (rsp_thrust_bits),
      .rsp_rate_x_bits (rsp_rate_x_bits),
      .rsp_rate_y_bits (rsp_rate_y_bits),
      .rsp_rate_z_bits (rsp_rate_z_bits),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   frame_checker #(
      .FRAME_BYTES (FRAME_BYTES)
   ) check_unit (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_thrust_bits (rsp_thrust_bits),
      .rsp_rate_x_bits (rsp_rate_x_bits),
      .rsp_rate_y_bits (rsp_rate_y_bits),
      .rsp_rate_z_bits (rsp_rate_z_bits),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .mismatches      (mismatches),
      .frames_awaited  (frames_awaited)
   );

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(input logic idx);
      logic [CSR_ADDR_W-1:0] a;
      a    = '0;
      a[2] = idx;
      return a;
   endfunction

   // One APB transfer: a setup phase, then the access phase until pready.
   // The bus is then left idle so that back-to-back transfers never lower
   // and raise psel within the same step.
   task automatic csr_access(input logic idx, input logic wr, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= reg_addr(idx);
      pwdata  <= {{(CSR_DATA_W-8){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Programs both markers and reads them back; the checker compares the
   // read data against its own copy.
   task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
      csr_access(REG_START_MARKER, 1'b1, s);
      csr_access(REG_END_MARKER, 1'b1, e);
      csr_access(REG_START_MARKER, 1'b0, 8'h00);
      csr_access(REG_END_MARKER, 1'b0, 8'h00);
      cur_start = s;
      cur_end   = e;
   endtask

   // Offers one byte and holds it until the block takes it. The sender
   // works in bursts; at the start of each burst it may leave a gap.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Stops offering and waits until every frame the checker expects has
   // come out, then lets the pipeline run empty before the bus is touched.
   task automatic drain();
      req_valid <= 1'b0;
      while (frames_awaited != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   // Builds one frame around the current markers. A bad frame gets a wrong
   // checksum byte. An overlapping frame hides a start marker inside its
   // payload and is followed by just enough bytes for a second window,
   // sharing bytes with the first, to end on the end marker.
   task automatic send_frame(input frame_kind_t kind);
      logic [7:0] fr [FRAME_BYTES];
      logic [7:0] sum;
      int         cut;
      cut                 = 0;
      fr[0]               = cur_start;
      fr[FRAME_BYTES - 1] = cur_end;
      for (int i = 2; i <= FRAME_BYTES - 2; i++) fr[i] = 8'($urandom_range(0, 255));
      if (kind == FR_OVERLAP) begin
         cut     = $urandom_range(2, FRAME_BYTES - 2);
         fr[cut] = cur_start;
      end
      sum = '0;
      for (int i = 2; i <= FRAME_BYTES - 2; i++) sum ^= fr[i];
      fr[1] = (kind == FR_BAD_SUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
      for (int i = 0; i < FRAME_BYTES; i++) send_byte(fr[i]);
      if (kind == FR_OVERLAP) begin
         repeat (cut - 1) send_byte(8'($urandom_range(0, 255)));
         send_byte(cur_end);
      end
   endtask

   // Line noise: random bytes with an occasional stray marker in them.
   task automatic send_noise();
      logic [7:0] b;
      int         n;
      n = $urandom_range(1, 24);
      repeat (n) begin
         b = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? cur_start : cur_end;
         send_byte(b);
      end
   endtask

   // Result side. It runs through stretches of different stall density,
   // including stretches with no stall at all. Once, on request, it holds
   // off for a long time so that the block fills and stalls its input.
   initial begin : result_side
      stall_mode_t mode;
      int          run_left;
      bit          hold_done;
      mode      = STALL_NONE;
      run_left  = 0;
      hold_done = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (run_left == 0) begin
               mode     = stall_mode_t'($urandom_range(0, 3));
               run_left = $urandom_range(20, 200);
            end
            run_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
               default:     rsp_stall <= ($urandom_range(0, 4) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // Hard stop in case the block hangs or loses a handshake.
   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $error("no progress within %0d cycles", LIMIT_CYCLES);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [7:0]  prelude [4];
      logic [7:0]  probe [FRAME_BYTES];
      int          pick;
      int          goal;
      frame_kind_t kind;

      // The first four bytes run while the window is still filling up.
      prelude = '{8'h40, 8'h00, 8'hFF, 8'hA5};

      // A well-formed frame with all-ones and all-zero words. Its checksum
      // byte equals the start marker, so one more end marker turns the
      // shifted window into an overlapping frame with a bad checksum.
      probe = '{8'h40, 8'h40,
                8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h00, 8'h00, 8'h00, 8'h00,
                8'h01, 8'h80, 8'h7F, 8'h55,
                8'h12, 8'h34, 8'h56, 8'h9B,
                8'h2B};

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values of the markers are checked by reading before any write.
      csr_access(REG_START_MARKER, 1'b0, 8'h00);
      csr_access(REG_END_MARKER, 1'b0, 8'h00);

      // With an end marker of zero, the unwritten cells at the back of a
      // window that is not yet full match it, so every early byte that
      // leaves the start marker in front produces a result item.
      set_markers(8'h40, 8'h00);
      foreach (prelude[i]) send_byte(prelude[i]);
      drain();

      set_markers(START_MARKER_RST, END_MARKER_RST);
      foreach (probe[i]) send_byte(probe[i]);
      send_byte(END_MARKER_RST);
      drain();

      // Random part: one phase per marker setting, extremes first. Frames
      // dominate so that most windows get past the marker test.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       set_markers(8'h40, 8'h2B);
            1:       set_markers(8'h00, 8'hFF);
            2:       set_markers(8'hFF, 8'h00);
            3:       set_markers(8'h7E, 8'h7E);
            default: set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         // The long result hold-off lands while the sender streams frames.
         if (phase == 1) hold_off_req = 1'b1;
         goal = bytes_sent + PHASE_BYTES;
         while (bytes_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 62)      kind = FR_GOOD;
            else if (pick < 74) kind = FR_BAD_SUM;
            else if (pick < 86) kind = FR_OVERLAP;
            else                kind = FR_NOISE;
            if (kind == FR_NOISE) send_noise();
            else                  send_frame(kind);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
